FILE: src/lrupr_pkg.sv
// Shared constants, types and helpers for the LRU page replacement block.
package lrupr_pkg;

  localparam int PAGE_W  = 16;   // page field width on the ports
  localparam int SLOT_W  = 4;    // slot field width on the result
  localparam int CNT_W   = 32;   // request / miss counters and age stamps
  localparam int TSIZE_W = 5;    // table_size register width

  localparam logic [TSIZE_W-1:0] TSIZE_RST = 5'd16;

  // Control tag that rides along the scan chain with each candidate.
  typedef struct packed {
    logic tok;    // a scan is passing this point
    logic first;  // no candidate taken yet
  } scan_tag_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

FILE: src/lrupr_if.sv
// Channel interfaces: page request, result and table_size write.
interface lrupr_req_if import lrupr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lrupr_rsp_if import lrupr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              evicted;
  logic [PAGE_W-1:0] evicted_page;
  logic [CNT_W-1:0]  request_count;
  logic [CNT_W-1:0]  miss_count;

  modport source (output valid, output hit, output slot, output evicted,
                  output evicted_page, output request_count, output miss_count,
                  input ready);
  modport sink   (input valid, input hit, input slot, input evicted,
                  input evicted_page, input request_count, input miss_count,
                  output ready);
endinterface

interface lrupr_cfg_if import lrupr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TSIZE_W-1:0] table_size;

  modport source (output valid, output table_size, input ready);
  modport sink   (input valid, input table_size, output ready);
endinterface

FILE: src/lrupr_cell.sv
// One table entry: holds a page and its age stamp, compares and passes the scan.
module lrupr_cell import lrupr_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int PW  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PW-1:0]    lookup_page_i,
  output logic             match_o,
  input  logic             wr_en_i,
  input  logic [IW-1:0]    wr_slot_i,
  input  logic [PW-1:0]    wr_page_i,
  input  logic [CNT_W-1:0] wr_age_i,
  input  scan_tag_t        scan_tag_i,
  input  logic [CNT_W-1:0] scan_age_i,
  input  logic [IW-1:0]    scan_idx_i,
  input  logic [PW-1:0]    scan_page_i,
  output scan_tag_t        scan_tag_o,
  output logic [CNT_W-1:0] scan_age_o,
  output logic [IW-1:0]    scan_idx_o,
  output logic [PW-1:0]    scan_page_o
);

  logic [PW-1:0]    page_q;
  logic [CNT_W-1:0] age_q;
  logic             take;

  assign match_o = (page_q == lookup_page_i);

  // strict less keeps the lower slot on equal stamps
  assign take = scan_tag_i.tok && (scan_tag_i.first || (age_q < scan_age_i));

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_slot_i == IW'(IDX))) begin
      page_q <= wr_page_i;
      age_q  <= wr_age_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_tag_o <= '0;
    end else begin
      scan_tag_o.tok   <= scan_tag_i.tok;
      scan_tag_o.first <= scan_tag_i.first && !take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      scan_age_o  <= age_q;
      scan_idx_o  <= IW'(IDX);
      scan_page_o <= page_q;
    end else begin
      scan_age_o  <= scan_age_i;
      scan_idx_o  <= scan_idx_i;
      scan_page_o <= scan_page_i;
    end
  end

endmodule

FILE: src/lru_page_replacement_core.sv
// Top level of the LRU page replacement block: control, counters and cell chain.
//
// Fully associative page table with least recently used replacement.
// req_i carries one page number per transaction; page zero is dropped
// without a result. rsp_o returns one result per nonzero page: hit flag,
// slot, eviction flag and page, and the saturating request and miss counts.
// cfg_i writes table_size (slots in use); it is always ready and must only
// be written while the block is idle.
// Flow: a hit or a fill into a free slot passes ST_LOOK and ST_DONE on
// its way to the result register; the next request is taken in the cycle
// the result appears. An eviction also passes ST_SCAN, which walks the age
// stamps through the cell chain, one cell per cycle, before ST_DONE. The
// lookup compares all cells in parallel.
// One request is worked on at a time; the result register lets a new
// request in while the previous result waits. If rsp_o stalls and the
// result register is still full, the block holds the finished item.
// Reset empties the table (fill count zero), clears both counters and sets
// table_size to 16, limited to ENTRIES. No clearing pass is needed.
module lru_page_replacement_core import lrupr_pkg::*; #(
  parameter int ENTRIES   = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lrupr_req_if.sink    req_i,
  lrupr_rsp_if.source  rsp_o,
  lrupr_cfg_if.sink    cfg_i
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e             state_q;
  logic [TSIZE_W-1:0] table_size_q;
  logic [CW-1:0]      fill_count_q;
  logic [CNT_W-1:0]   req_cnt_q;
  logic [CNT_W-1:0]   miss_cnt_q;
  logic [PW-1:0]      page_q;
  logic               hit_q;
  logic               fill_q;
  logic               evict_q;
  logic [IW-1:0]      slot_q;
  logic [PW-1:0]      victim_q;
  logic               out_valid_q;

  logic [CW-1:0]      size;
  logic [CW-1:0]      filled;
  logic [PW-1:0]      page_in;
  logic               accept;
  logic               has_room;
  logic               look_hit;
  logic [IW-1:0]      hit_idx;
  logic               scan_start;
  logic               scan_done;
  logic [IW-1:0]      last_idx;
  logic               out_load;
  logic [ENTRIES-1:0] match_v;

  scan_tag_t          tag_o  [ENTRIES];
  logic [CNT_W-1:0]   age_o  [ENTRIES];
  logic [IW-1:0]      idx_o  [ENTRIES];
  logic [PW-1:0]      page_o [ENTRIES];

  // slots in use: zero acts as one, capped at the built capacity
  always_comb begin
    if (table_size_q == '0) begin
      size = CW'(1);
    end else if (32'(table_size_q) > 32'(ENTRIES)) begin
      size = CW'(ENTRIES);
    end else begin
      size = CW'(table_size_q);
    end
  end

  assign filled   = (fill_count_q < size) ? fill_count_q : size;
  assign has_room = (fill_count_q < size);
  assign last_idx = IW'(size - 1'b1);
  assign page_in  = req_i.page[PW-1:0];

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = req_i.valid && (state_q == ST_IDLE) && (page_in != '0);

  // first matching filled slot
  always_comb begin
    look_hit = 1'b0;
    hit_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_v[i] && (CW'(i) < filled)) begin
        look_hit = 1'b1;
        hit_idx  = IW'(i);
      end
    end
  end

  assign scan_start = (state_q == ST_LOOK) && !look_hit && !has_room;
  assign scan_done  = (state_q == ST_SCAN) && tag_o[last_idx].tok;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    scan_tag_t        tag_in;
    logic [CNT_W-1:0] age_in;
    logic [IW-1:0]    idx_in;
    logic [PW-1:0]    page_in_c;

    if (i == 0) begin : g_head
      assign tag_in    = '{tok: scan_start, first: 1'b1};
      assign age_in    = '1;
      assign idx_in    = '0;
      assign page_in_c = '0;
    end else begin : g_link
      // the scan token stops after the last slot in use
      assign tag_in    = (IW'(i - 1) == last_idx) ? scan_tag_t'('0) : tag_o[i-1];
      assign age_in    = age_o[i-1];
      assign idx_in    = idx_o[i-1];
      assign page_in_c = page_o[i-1];
    end

    lrupr_cell #(
      .IDX (i),
      .IW  (IW),
      .PW  (PW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .lookup_page_i (page_q),
      .match_o       (match_v[i]),
      .wr_en_i       (out_load),
      .wr_slot_i     (slot_q),
      .wr_page_i     (page_q),
      .wr_age_i      (req_cnt_q),
      .scan_tag_i    (tag_in),
      .scan_age_i    (age_in),
      .scan_idx_i    (idx_in),
      .scan_page_i   (page_in_c),
      .scan_tag_o    (tag_o[i]),
      .scan_age_o    (age_o[i]),
      .scan_idx_o    (idx_o[i]),
      .scan_page_o   (page_o[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      table_size_q <= TSIZE_RST;
      fill_count_q <= '0;
      req_cnt_q    <= '0;
      miss_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        table_size_q <= cfg_i.table_size;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q   <= ST_LOOK;
            req_cnt_q <= sat_inc(req_cnt_q);
          end
        end
        ST_LOOK: begin
          state_q <= (look_hit || has_room) ? ST_DONE : ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
            if (!hit_q) begin
              miss_cnt_q <= sat_inc(miss_cnt_q);
            end
            if (fill_q) begin
              fill_count_q <= fill_count_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= page_in;
    end
    if (state_q == ST_LOOK) begin
      hit_q    <= look_hit;
      fill_q   <= !look_hit && has_room;
      evict_q  <= !look_hit && !has_room;
      slot_q   <= look_hit ? hit_idx : IW'(fill_count_q);
      victim_q <= '0;
    end else if (scan_done) begin
      slot_q   <= idx_o[last_idx];
      victim_q <= page_o[last_idx];
    end
    if (out_load) begin
      rsp_o.hit           <= hit_q;
      rsp_o.slot          <= SLOT_W'(slot_q);
      rsp_o.evicted       <= evict_q;
      rsp_o.evicted_page  <= PAGE_W'(victim_q);
      rsp_o.request_count <= req_cnt_q;
      rsp_o.miss_count    <= hit_q ? miss_cnt_q : sat_inc(miss_cnt_q);
    end
  end

  assign rsp_o.valid = out_valid_q;

  // scan leaves the last slot in use only while the controller waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_o[last_idx].tok |-> (state_q == ST_SCAN))
    else $error("scan result outside of scan state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_count_q <= CW'(ENTRIES))
    else $error("fill count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_cnt_q <= req_cnt_q)
    else $error("more misses than requests");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && evict_q) |-> (fill_count_q >= size))
    else $error("eviction while free slots remain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("result load did not complete the transaction");

endmodule
